[design/combined_bipred_merge_candidates_defines.svh]
// ----------------------------------------------------------------------------
// Combined bi-predictive merge candidates: assertion macros
// Shared concurrent assertion forms for the block's own checks.
// ----------------------------------------------------------------------------
`ifndef COMBINED_BIPRED_MERGE_CANDIDATES_DEFINES_SVH
`define COMBINED_BIPRED_MERGE_CANDIDATES_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define CBMC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define CBMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/cbmc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Combined bi-predictive merge candidates: shared package
// Types and constants used by front, queue and back end, and the pairing table of the back end.
// ----------------------------------------------------------------------------
package cbmc_pkg;

   // Number of stored original candidates.
   localparam int STORE_DEPTH = 4;
   localparam int SLOT_W = $clog2(STORE_DEPTH);
   // Entries in the pairing table.
   localparam int PAIR_COUNT = 12;
   localparam int PAIR_W = $clog2(PAIR_COUNT);
   // Depth of the queue between front and back end.
   localparam int JOB_QUEUE_DEPTH = 2;

   // One classified candidate word handed from front to back end.
   typedef struct packed {
      logic              pred_l0;
      logic              pred_l1;
      logic [3:0]        ref_idx_l0;
      logic [3:0]        ref_idx_l1;
      logic [31:0]       mv_l0;      // {y, x}
      logic [31:0]       mv_l1;      // {y, x}
      logic [31:0]       poc_l0;
      logic [31:0]       poc_l1;
      logic              store_en;   // the candidate fits in the store
      logic [SLOT_W-1:0] slot;       // store entry to write
      logic              last;       // final candidate of the unit
      logic              run;        // the pair walk runs after this word
      logic [2:0]        cnt;        // candidates counted in the unit
      logic [2:0]        maxc;       // effective merge list size
      logic [PAIR_W-1:0] limit;      // table entries to check
   } job_type;

   // One result word.
   typedef struct packed {
      logic               found;
      logic [2:0]         slot;
      logic [3:0]         ref_idx_l0;
      logic [3:0]         ref_idx_l1;
      logic signed [15:0] mv_l0_x;
      logic signed [15:0] mv_l0_y;
      logic signed [15:0] mv_l1_x;
      logic signed [15:0] mv_l1_y;
      logic               last;
   } rsp_type;

   // Back end status seen by the top level.
   typedef struct packed {
      logic       busy;
      logic       walking;
      logic [2:0] cur;
   } back_status_type;

   // Back end sequencer states.
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_CHECK,
      BK_FLUSH
   } back_state_type;

   // Candidate that supplies the list 0 data of a table entry.
   function automatic logic [SLOT_W-1:0] pair_first(input logic [PAIR_W-1:0] k);
      logic [SLOT_W-1:0] r;
      case (k)
         4'd0:    r = 2'd0;
         4'd1:    r = 2'd1;
         4'd2:    r = 2'd0;
         4'd3:    r = 2'd2;
         4'd4:    r = 2'd1;
         4'd5:    r = 2'd2;
         4'd6:    r = 2'd0;
         4'd7:    r = 2'd3;
         4'd8:    r = 2'd1;
         4'd9:    r = 2'd3;
         4'd10:   r = 2'd2;
         4'd11:   r = 2'd3;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

   // Candidate that supplies the list 1 data of a table entry.
   function automatic logic [SLOT_W-1:0] pair_second(input logic [PAIR_W-1:0] k);
      logic [SLOT_W-1:0] r;
      case (k)
         4'd0:    r = 2'd1;
         4'd1:    r = 2'd0;
         4'd2:    r = 2'd2;
         4'd3:    r = 2'd0;
         4'd4:    r = 2'd2;
         4'd5:    r = 2'd1;
         4'd6:    r = 2'd3;
         4'd7:    r = 2'd0;
         4'd8:    r = 2'd3;
         4'd9:    r = 2'd1;
         4'd10:   r = 2'd3;
         4'd11:   r = 2'd2;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

endpackage

[design/cbmc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Combined bi-predictive merge candidates: channel interfaces
// Valid/ready channels for candidate words, result words and the register.
// ----------------------------------------------------------------------------

// Candidate word channel.
interface cbmc_req_if;
   logic               valid;
   logic               ready;
   logic               pred_l0;
   logic               pred_l1;
   logic [3:0]         ref_idx_l0;
   logic [3:0]         ref_idx_l1;
   logic signed [15:0] mv_l0_x;
   logic signed [15:0] mv_l0_y;
   logic signed [15:0] mv_l1_x;
   logic signed [15:0] mv_l1_y;
   logic signed [31:0] poc_ref_l0;
   logic signed [31:0] poc_ref_l1;
   logic               last_cand;

   modport source (
      output valid, pred_l0, pred_l1, ref_idx_l0, ref_idx_l1, mv_l0_x, mv_l0_y,
             mv_l1_x, mv_l1_y, poc_ref_l0, poc_ref_l1, last_cand,
      input  ready
   );
   modport sink (
      input  valid, pred_l0, pred_l1, ref_idx_l0, ref_idx_l1, mv_l0_x, mv_l0_y,
             mv_l1_x, mv_l1_y, poc_ref_l0, poc_ref_l1, last_cand,
      output ready
   );
endinterface

// Result word channel.
interface cbmc_rsp_if;
   logic               valid;
   logic               ready;
   logic               found;
   logic [2:0]         slot;
   logic [3:0]         out_ref_idx_l0;
   logic [3:0]         out_ref_idx_l1;
   logic signed [15:0] out_mv_l0_x;
   logic signed [15:0] out_mv_l0_y;
   logic signed [15:0] out_mv_l1_x;
   logic signed [15:0] out_mv_l1_y;
   logic               last_out;

   modport source (
      output valid, found, slot, out_ref_idx_l0, out_ref_idx_l1, out_mv_l0_x,
             out_mv_l0_y, out_mv_l1_x, out_mv_l1_y, last_out,
      input  ready
   );
   modport sink (
      input  valid, found, slot, out_ref_idx_l0, out_ref_idx_l1, out_mv_l0_x,
             out_mv_l0_y, out_mv_l1_x, out_mv_l1_y, last_out,
      output ready
   );
endinterface

// Register write channel for max_merge_cand.
interface cbmc_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

[design/cbmc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Combined bi-predictive merge candidates: front end
// Accepts candidate words, counts them per unit and decides the pair walk.
// ----------------------------------------------------------------------------
module cbmc_front #(
   parameter int MAX_MERGE_CAND = 5
) (
   input  logic              clock,
   input  logic              reset,
   cbmc_req_if.sink          req,
   cbmc_csr_if.sink          csr,
   output logic              job_valid,
   output cbmc_pkg::job_type job,
   input  logic              job_ready
);
   import cbmc_pkg::*;

   localparam logic [2:0] MaxcLimit = 3'(MAX_MERGE_CAND);
   localparam logic [2:0] CountSat = 3'(STORE_DEPTH + 1);

   logic [2:0] max_ff;
   logic [2:0] cnt_ff;
   logic [2:0] cnt_in;
   logic [2:0] n_next;
   logic [2:0] maxc;
   logic       accept;

   // The register port never stalls.
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= 3'd5;
      end else if (csr.valid) begin
         max_ff <= csr.data;
      end
   end

   // A word is taken whenever the queue has room.
   assign req.ready = job_ready;
   assign job_valid = req.valid;
   assign accept = req.valid && job_ready;

   // Saturating count including the word now arriving.
   assign n_next = (cnt_ff == CountSat) ? CountSat : cnt_ff + 3'd1;
   assign maxc = (max_ff > MaxcLimit) ? MaxcLimit : max_ff;
   assign cnt_in = req.last_cand ? 3'd0 : n_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
      end else if (accept) begin
         cnt_ff <= cnt_in;
      end
   end

   // Classify the word for the back end.
   always_comb begin
      job.pred_l0    = req.pred_l0;
      job.pred_l1    = req.pred_l1;
      job.ref_idx_l0 = req.ref_idx_l0;
      job.ref_idx_l1 = req.ref_idx_l1;
      job.mv_l0      = {req.mv_l0_y, req.mv_l0_x};
      job.mv_l1      = {req.mv_l1_y, req.mv_l1_x};
      job.poc_l0     = req.poc_ref_l0;
      job.poc_l1     = req.poc_ref_l1;
      job.store_en   = (cnt_ff < 3'(STORE_DEPTH));
      job.slot       = cnt_ff[SLOT_W-1:0];
      job.last       = req.last_cand;
      job.run        = (n_next > 3'd1) && (maxc > n_next) &&
                       (n_next <= 3'(STORE_DEPTH));
      job.cnt        = n_next;
      job.maxc       = maxc;
      case (n_next)
         3'd2:    job.limit = 4'd2;
         3'd3:    job.limit = 4'd6;
         default: job.limit = 4'(PAIR_COUNT);
      endcase
   end

endmodule

[design/cbmc_job_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Combined bi-predictive merge candidates: job queue
// Short queue of classified candidate words between front and back end.
// ----------------------------------------------------------------------------
module cbmc_job_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  cbmc_pkg::job_type in_job,
   output logic              in_ready,
   output logic              out_valid,
   output cbmc_pkg::job_type out_job,
   input  logic              out_ready,
   output logic              full
);
   import cbmc_pkg::*;

   localparam int PtrW = $clog2(JOB_QUEUE_DEPTH);
   localparam int CntW = $clog2(JOB_QUEUE_DEPTH + 1);

   job_type         entry_ff [JOB_QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff;
   logic [PtrW-1:0] rd_ptr_ff;
   logic [CntW-1:0] count_ff;
   logic            push;
   logic            pop;

   assign full = (count_ff == CntW'(JOB_QUEUE_DEPTH));
   assign in_ready = !full;
   assign out_valid = (count_ff != '0);
   assign out_job = entry_ff[rd_ptr_ff];
   assign push = in_valid && !full;
   assign pop = out_valid && out_ready;

   // Payload storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_job;
      end
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(JOB_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(JOB_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

[design/cbmc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Combined bi-predictive merge candidates: back end
// Stores candidates, walks the pairing table and issues result words.
// ----------------------------------------------------------------------------
module cbmc_back #(
   parameter int POC_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      job_valid,
   input  cbmc_pkg::job_type         job,
   output logic                      job_ready,
   cbmc_rsp_if.source                rsp,
   output cbmc_pkg::back_status_type status
);
   import cbmc_pkg::*;

   // Candidate store, one entry per original candidate.
   logic [1:0]           flags_mem [STORE_DEPTH];
   logic [7:0]           ref_mem   [STORE_DEPTH];
   logic [31:0]          mv0_mem   [STORE_DEPTH];
   logic [31:0]          mv1_mem   [STORE_DEPTH];
   logic [POC_WIDTH-1:0] poc0_mem  [STORE_DEPTH];
   logic [POC_WIDTH-1:0] poc1_mem  [STORE_DEPTH];

   // Registered read data: port A for list 0, port B for list 1.
   logic [1:0]           flags_a_ff;
   logic [1:0]           flags_b_ff;
   logic [3:0]           ref_a_ff;
   logic [3:0]           ref_b_ff;
   logic [31:0]          mv_a_ff;
   logic [31:0]          mv_b_ff;
   logic [POC_WIDTH-1:0] poc_a_ff;
   logic [POC_WIDTH-1:0] poc_b_ff;

   back_state_type    st_ff;
   back_state_type    st_in;
   logic [PAIR_W-1:0] k_ff;
   logic [PAIR_W-1:0] k_in;
   logic [2:0]        cur_ff;
   logic [2:0]        cur_in;
   logic [PAIR_W-1:0] limit_ff;
   logic [2:0]        maxc_ff;
   logic              pend_valid_ff;
   rsp_type           pend_ff;
   logic              out_valid_ff;
   rsp_type           out_ff;

   logic              job_pop;
   logic              out_free;
   logic              match;
   logic              step;
   logic              walk_more;
   logic              push_out;
   rsp_type           push_data;
   rsp_type           new_res;
   logic [SLOT_W-1:0] addr_a;
   logic [SLOT_W-1:0] addr_b;

   assign addr_a = pair_first(k_ff);
   assign addr_b = pair_second(k_ff);

   // Store writes on each popped word that fits in the store; reads follow the table entry.
   always_ff @(posedge clock) begin
      if (job_pop && job.store_en) begin
         flags_mem[job.slot] <= {job.pred_l1, job.pred_l0};
         ref_mem[job.slot]   <= {job.ref_idx_l1, job.ref_idx_l0};
         mv0_mem[job.slot]   <= job.mv_l0;
         mv1_mem[job.slot]   <= job.mv_l1;
         poc0_mem[job.slot]  <= job.poc_l0[POC_WIDTH-1:0];
         poc1_mem[job.slot]  <= job.poc_l1[POC_WIDTH-1:0];
      end
      flags_a_ff <= flags_mem[addr_a];
      ref_a_ff   <= ref_mem[addr_a][3:0];
      mv_a_ff    <= mv0_mem[addr_a];
      poc_a_ff   <= poc0_mem[addr_a];
      flags_b_ff <= flags_mem[addr_b];
      ref_b_ff   <= ref_mem[addr_b][7:4];
      mv_b_ff    <= mv1_mem[addr_b];
      poc_b_ff   <= poc1_mem[addr_b];
   end

   // Pair check on the registered read data.
   assign match = flags_a_ff[0] && flags_b_ff[1] &&
                  ((poc_a_ff != poc_b_ff) || (mv_a_ff != mv_b_ff));

   always_comb begin
      new_res.found      = 1'b1;
      new_res.slot       = cur_ff;
      new_res.ref_idx_l0 = ref_a_ff;
      new_res.ref_idx_l1 = ref_b_ff;
      new_res.mv_l0_x    = mv_a_ff[15:0];
      new_res.mv_l0_y    = mv_a_ff[31:16];
      new_res.mv_l1_x    = mv_b_ff[15:0];
      new_res.mv_l1_y    = mv_b_ff[31:16];
      new_res.last       = 1'b0;
   end

   assign out_free = !out_valid_ff || rsp.ready;
   // A check may retire unless it has to hand a held result to a full output.
   assign step = !(match && pend_valid_ff && !out_free);
   assign cur_in = match ? cur_ff + 3'd1 : cur_ff;
   assign k_in = k_ff + 4'd1;
   assign walk_more = (k_in < limit_ff) && (cur_in < maxc_ff);

   // Next state.
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         BK_IDLE: begin
            if (job_valid && job.last) begin
               st_in = job.run ? BK_READ : BK_FLUSH;
            end
         end
         BK_READ: begin
            st_in = BK_CHECK;
         end
         BK_CHECK: begin
            if (step) begin
               st_in = walk_more ? BK_READ : BK_FLUSH;
            end
         end
         BK_FLUSH: begin
            if (out_free) begin
               st_in = BK_IDLE;
            end
         end
         default: st_in = BK_IDLE;
      endcase
   end

   // State outputs: queue pop and result hand-off.
   always_comb begin
      job_ready = 1'b0;
      push_out  = 1'b0;
      push_data = pend_ff;
      unique case (st_ff)
         BK_IDLE: begin
            job_ready = 1'b1;
         end
         BK_READ: begin
         end
         BK_CHECK: begin
            // A newer match proves the held result is not the final one.
            push_out = match && pend_valid_ff && out_free;
            push_data.last = 1'b0;
         end
         BK_FLUSH: begin
            push_out = out_free;
            if (pend_valid_ff) begin
               push_data.last = 1'b1;
            end else begin
               push_data = '0;
               push_data.last = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign job_pop = job_valid && job_ready;

   // Walk control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= BK_IDLE;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (st_ff == BK_CHECK && step && match) begin
            pend_valid_ff <= 1'b1;
         end else if (st_ff == BK_FLUSH && out_free) begin
            pend_valid_ff <= 1'b0;
         end
         if (push_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Walk payload registers.
   always_ff @(posedge clock) begin
      if (job_pop) begin
         k_ff     <= '0;
         cur_ff   <= job.cnt;
         limit_ff <= job.limit;
         maxc_ff  <= job.maxc;
      end else if (st_ff == BK_CHECK && step) begin
         k_ff   <= k_in;
         cur_ff <= cur_in;
      end
      if (st_ff == BK_CHECK && step && match) begin
         pend_ff <= new_res;
      end
      if (push_out) begin
         out_ff <= push_data;
      end
   end

   // Result port.
   assign rsp.valid          = out_valid_ff;
   assign rsp.found          = out_ff.found;
   assign rsp.slot           = out_ff.slot;
   assign rsp.out_ref_idx_l0 = out_ff.ref_idx_l0;
   assign rsp.out_ref_idx_l1 = out_ff.ref_idx_l1;
   assign rsp.out_mv_l0_x    = out_ff.mv_l0_x;
   assign rsp.out_mv_l0_y    = out_ff.mv_l0_y;
   assign rsp.out_mv_l1_x    = out_ff.mv_l1_x;
   assign rsp.out_mv_l1_y    = out_ff.mv_l1_y;
   assign rsp.last_out       = out_ff.last;

   assign status.busy    = (st_ff != BK_IDLE);
   assign status.walking = (st_ff == BK_READ) || (st_ff == BK_CHECK);
   assign status.cur     = cur_ff;

endmodule

[design/combined_bipred_merge_candidates.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Combined bi-predictive merge candidates: top level
// Front end, job queue and back end that build combined merge candidates.
// ----------------------------------------------------------------------------
//
//   channel  dir  moves
//   req_ch   in   one original merge candidate per word
//   rsp_ch   out  one combined candidate, or the "none" word, per word
//   csr_ch   in   max_merge_cand write, always ready
//
// A candidate word passes through the front end, the job queue and the back end.
// After the last word of a unit the back end checks pairing table entries one
// at a time (store read, then compare; a stalled result port can hold a compare),
// up to twelve entries, then hands off the final result.
// Reset is synchronous and active high and clears all control state.
// A stalled result port holds the back end; the front end keeps taking words
// until the two-entry job queue is full.
module combined_bipred_merge_candidates #(
   parameter int MAX_MERGE_CAND = 5,
   parameter int POC_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   cbmc_req_if.sink    req_ch,
   cbmc_rsp_if.source  rsp_ch,
   cbmc_csr_if.sink    csr_ch
);
   import cbmc_pkg::*;

`include "combined_bipred_merge_candidates_defines.svh"

   logic            fr_valid;
   job_type         fr_job;
   logic            fr_ready;
   logic            q_valid;
   job_type         q_job;
   logic            q_ready;
   logic            q_full;
   back_status_type bk_status;

   // Front end: counting and classification.
   cbmc_front #(
      .MAX_MERGE_CAND (MAX_MERGE_CAND)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .csr       (csr_ch),
      .job_valid (fr_valid),
      .job       (fr_job),
      .job_ready (fr_ready)
   );

   // Queue between the two halves.
   cbmc_job_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_job    (fr_job),
      .in_ready  (fr_ready),
      .out_valid (q_valid),
      .out_job   (q_job),
      .out_ready (q_ready),
      .full      (q_full)
   );

   // Back end: candidate store and pair walk.
   cbmc_back #(
      .POC_WIDTH (POC_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (q_valid),
      .job       (q_job),
      .job_ready (q_ready),
      .rsp       (rsp_ch),
      .status    (bk_status)
   );

   // The front end must stall while the queue is full.
   `CBMC_ASSERT_SAME(a_full_stalls, clock, reset, q_full, !req_ch.ready, "word taken while queue full")
   // The "none" word closes its unit and carries slot zero.
   `CBMC_ASSERT_SAME(a_none_last, clock, reset, rsp_ch.valid && !rsp_ch.found, rsp_ch.last_out && (rsp_ch.slot == 3'd0), "malformed none word")
   // The walk never points past the merge list.
   `CBMC_ASSERT_SAME(a_cur_range, clock, reset, bk_status.walking, bk_status.cur < 3'(MAX_MERGE_CAND), "merge list position out of range")
   // The last word of a unit always starts a walk or a final hand-off.
   `CBMC_ASSERT_NEXT(a_last_busy, clock, reset, q_valid && q_ready && q_job.last, bk_status.busy, "last word did not start the back end")

endmodule
